@@ hw/rtl/nsf_pkg.sv @@
// nsf_pkg: shared types, constants and the microcode store of the newton square root block
// used by nsf_div, nsf_seq and newton_sqrt_fixed; depends on nothing

package nsf_pkg;

   // default parameter values
   localparam int MAX_STEPS_DEF = 63;
   localparam int FRAC_BITS_DEF = 16;

   // field and datapath widths
   localparam int RADICAND_W  = 31;
   localparam int STEP_W      = 6;
   localparam int ROOT_W      = 48;
   localparam int XW          = 64;
   localparam int STEP_CALC_W = 8;
   localparam int PC_W        = 3;

   typedef logic [PC_W-1:0] pc_type;

   // microcode step addresses
   localparam pc_type PC_WAIT   = 3'd0;
   localparam pc_type PC_ZCHK   = 3'd1;
   localparam pc_type PC_LOOP   = 3'd2;
   localparam pc_type PC_START  = 3'd3;
   localparam pc_type PC_ITER   = 3'd4;
   localparam pc_type PC_UPDATE = 3'd5;
   localparam pc_type PC_DONE   = 3'd6;
   localparam pc_type PC_RETIRE = 3'd7;

   // jump conditions: a true condition loads the target, otherwise the next step follows
   typedef enum logic [2:0] {
      COND_NEVER,
      COND_ALWAYS,
      COND_NO_REQ,
      COND_ZERO,
      COND_NO_STEPS,
      COND_DIV_MORE,
      COND_OUT_BUSY
   } cond_type;

   typedef struct packed {
      logic     accept;
      logic     div_start;
      logic     div_iter;
      logic     x_update;
      logic     out_load;
      cond_type cond;
      pc_type   target;
   } cw_type;

   // status bits that the conditions test
   typedef struct packed {
      logic req_valid;
      logic zero;
      logic no_steps;
      logic div_more;
      logic out_busy;
   } status_type;

   typedef struct packed {
      logic [RADICAND_W-1:0] radicand;
      logic [STEP_W-1:0]     step_count;
   } req_type;

   typedef struct packed {
      logic [ROOT_W-1:0] root_estimate;
      logic              invalid;
   } rsp_type;

   // microcode store
   function automatic cw_type rom_word(pc_type pc);
      cw_type w;
      w = '{accept: 1'b0, div_start: 1'b0, div_iter: 1'b0, x_update: 1'b0,
            out_load: 1'b0, cond: COND_NEVER, target: PC_WAIT};
      unique case (pc)
         PC_WAIT: begin
            w.accept = 1'b1;
            w.cond   = COND_NO_REQ;
            w.target = PC_WAIT;
         end
         PC_ZCHK: begin
            w.cond   = COND_ZERO;
            w.target = PC_DONE;
         end
         PC_LOOP: begin
            w.cond   = COND_NO_STEPS;
            w.target = PC_DONE;
         end
         PC_START: begin
            w.div_start = 1'b1;
         end
         PC_ITER: begin
            w.div_iter = 1'b1;
            w.cond     = COND_DIV_MORE;
            w.target   = PC_ITER;
         end
         PC_UPDATE: begin
            w.x_update = 1'b1;
            w.cond     = COND_ALWAYS;
            w.target   = PC_LOOP;
         end
         PC_DONE: begin
            w.out_load = 1'b1;
            w.cond     = COND_OUT_BUSY;
            w.target   = PC_DONE;
         end
         PC_RETIRE: begin
            w.cond   = COND_ALWAYS;
            w.target = PC_WAIT;
         end
         default: begin
            w.cond   = COND_ALWAYS;
            w.target = PC_WAIT;
         end
      endcase
      return w;
   endfunction

endpackage

@@ hw/rtl/nsf_div.sv @@
// nsf_div: restoring bit-serial divider, one quotient bit per cycle while iter is high, saturating at 64 bits
// depends on nsf_pkg

module nsf_div #(
   parameter int FRAC_BITS = nsf_pkg::FRAC_BITS_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            start,
   input  logic                            iter,
   input  logic [nsf_pkg::RADICAND_W-1:0]  radicand,
   input  logic [nsf_pkg::XW-1:0]          divisor,
   output logic [nsf_pkg::XW-1:0]          quotient,
   output logic                            more
);

   localparam int SHIFT = 2 * FRAC_BITS;
   localparam int DW    = nsf_pkg::RADICAND_W + SHIFT;
   localparam int CNT_W = $clog2(DW + 1);
   localparam int XW    = nsf_pkg::XW;

   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [DW-1:0]    dvd_ff, dvd_in;
   logic [XW-1:0]    rem_ff, rem_in;
   logic [XW-1:0]    quo_ff, quo_in;
   logic [XW-1:0]    d_ff, d_in;
   logic             sat_ff, sat_in;
   logic [XW:0]      trial;
   logic [XW+1:0]    diff;
   logic             ge;

   // trial subtract of the divisor from the shifted remainder
   always_comb begin
      trial = {rem_ff, dvd_ff[DW-1]};
      diff  = {1'b0, trial} - {2'b00, d_ff};
      ge    = ~diff[XW+1];
   end

   // next values of the iteration registers
   always_comb begin
      cnt_in = cnt_ff;
      dvd_in = dvd_ff;
      rem_in = rem_ff;
      quo_in = quo_ff;
      d_in   = d_ff;
      sat_in = sat_ff;
      if (start) begin
         cnt_in = CNT_W'(DW);
         dvd_in = {radicand, {SHIFT{1'b0}}};
         rem_in = '0;
         quo_in = '0;
         d_in   = divisor;
         sat_in = 1'b0;
      end else if (iter) begin
         cnt_in = cnt_ff - CNT_W'(1);
         dvd_in = dvd_ff << 1;
         rem_in = ge ? diff[XW-1:0] : trial[XW-1:0];
         quo_in = {quo_ff[XW-2:0], ge};
         sat_in = sat_ff | quo_ff[XW-1];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else begin
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      dvd_ff <= dvd_in;
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      d_ff   <= d_in;
      sat_ff <= sat_in;
   end

   // a zero divisor or an overflowed quotient reads as all ones
   assign quotient = (sat_ff || (d_ff == '0)) ? '1 : quo_ff;
   assign more     = (cnt_ff != CNT_W'(1));

   a_iter_counted: assert property (@(posedge clock) disable iff (reset)
      iter |-> cnt_ff != '0)
      else $error("divider iterates with no bits left");

   a_start_loads: assert property (@(posedge clock) disable iff (reset)
      start |=> more && cnt_ff == CNT_W'(DW))
      else $error("divider start did not load the bit count");

endmodule

@@ hw/rtl/nsf_seq.sv @@
// nsf_seq: microcode sequencer, step counter over the control store with conditional jumps
// depends on nsf_pkg

module nsf_seq (
   input  logic                clock,
   input  logic                reset,
   input  nsf_pkg::status_type status,
   output nsf_pkg::cw_type     cw
);

   nsf_pkg::pc_type pc_ff, pc_in;
   logic            take;

   // control word of the current step
   assign cw = nsf_pkg::rom_word(pc_ff);

   // jump condition decode
   always_comb begin
      unique case (cw.cond)
         nsf_pkg::COND_NEVER:    take = 1'b0;
         nsf_pkg::COND_ALWAYS:   take = 1'b1;
         nsf_pkg::COND_NO_REQ:   take = ~status.req_valid;
         nsf_pkg::COND_ZERO:     take = status.zero;
         nsf_pkg::COND_NO_STEPS: take = status.no_steps;
         nsf_pkg::COND_DIV_MORE: take = status.div_more;
         nsf_pkg::COND_OUT_BUSY: take = status.out_busy;
         default:                take = 1'b1;
      endcase
   end

   // next step
   always_comb begin
      pc_in = take ? cw.target : nsf_pkg::pc_type'(pc_ff + 1'b1);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pc_ff <= nsf_pkg::PC_WAIT;
      end else begin
         pc_ff <= pc_in;
      end
   end

   a_iter_leaves_to_update: assert property (@(posedge clock) disable iff (reset)
      (pc_ff == nsf_pkg::PC_ITER && !status.div_more) |=> pc_ff == nsf_pkg::PC_UPDATE)
      else $error("division end did not lead to the estimate update");

endmodule

@@ hw/rtl/newton_sqrt_fixed.sv @@
// newton_sqrt_fixed: top level, newton square root in unsigned fixed point
// depends on nsf_pkg, nsf_div and nsf_seq
//
//   port group  | dir | handshake           | payload
//   req_*       | in  | req_valid/req_stall | nsf_pkg::req_type (radicand, step_count)
//   rsp_*       | out | rsp_valid/rsp_stall | nsf_pkg::rsp_type (root_estimate, invalid)
//
// one request at a time; s = step count after saturation at MAX_STEPS
// a request runs s newton steps, each a pass of the bit-serial divider, which gives one
// quotient bit a cycle over 31 + 2 * FRAC_BITS bits, followed by an estimate update
// a zero radicand skips the newton steps; reset returns the sequencer to the wait step
// req_stall is high outside the wait step; a held response stalls the sequencer at its end

module newton_sqrt_fixed #(
   parameter int MAX_STEPS = nsf_pkg::MAX_STEPS_DEF,
   parameter int FRAC_BITS = nsf_pkg::FRAC_BITS_DEF
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  nsf_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output nsf_pkg::rsp_type rsp_data
);

   localparam int SW     = $clog2(MAX_STEPS + 1);
   localparam int XW     = nsf_pkg::XW;
   localparam int CALC_W = nsf_pkg::STEP_CALC_W;

   nsf_pkg::cw_type     cw;
   nsf_pkg::status_type status;

   logic [nsf_pkg::RADICAND_W-1:0] n_ff, n_in;
   logic [XW-1:0]                  x_ff, x_in;
   logic [SW-1:0]                  steps_ff, steps_in;
   logic                           inv_ff, inv_in;
   nsf_pkg::rsp_type               out_ff, out_in;
   logic                           rsp_valid_ff, rsp_valid_in;
   logic [XW-1:0]                  quotient;
   logic                           div_more;
   logic                           accept;
   logic                           out_busy;
   logic                           out_load;
   logic [CALC_W-1:0]              step_req;
   logic [CALC_W-1:0]              step_sat;

   // sequencer and divider
   nsf_seq u_seq (
      .clock  (clock),
      .reset  (reset),
      .status (status),
      .cw     (cw)
   );

   nsf_div #(
      .FRAC_BITS (FRAC_BITS)
   ) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (cw.div_start),
      .iter     (cw.div_iter),
      .radicand (n_ff),
      .divisor  (x_ff),
      .quotient (quotient),
      .more     (div_more)
   );

   // handshake
   assign req_stall = ~cw.accept;
   assign accept    = req_valid & cw.accept;
   assign out_busy  = rsp_valid_ff & rsp_stall;
   assign out_load  = cw.out_load & ~out_busy;

   // status for the jump conditions
   always_comb begin
      status.req_valid = req_valid;
      status.zero      = (n_ff == '0);
      status.no_steps  = (steps_ff == '0);
      status.div_more  = div_more;
      status.out_busy  = out_busy;
   end

   // step count saturation
   always_comb begin
      step_req = CALC_W'(req_data.step_count);
      step_sat = (step_req > CALC_W'(MAX_STEPS)) ? CALC_W'(MAX_STEPS) : step_req;
   end

   // working registers: radicand, estimate, steps left, invalid flag
   always_comb begin
      n_in     = n_ff;
      x_in     = x_ff;
      steps_in = steps_ff;
      inv_in   = inv_ff;
      if (accept) begin
         n_in     = req_data.radicand;
         x_in     = XW'(req_data.radicand) << (FRAC_BITS - 1);
         steps_in = SW'(step_sat);
         inv_in   = (req_data.radicand == '0) && (req_data.step_count != '0);
      end else begin
         if (cw.div_start) begin
            steps_in = steps_ff - SW'(1);
         end
         // halve the sum of estimate and quotient without overflow
         if (cw.x_update) begin
            x_in = (x_ff >> 1) + (quotient >> 1) + XW'(x_ff[0] & quotient[0]);
         end
      end
   end

   always_ff @(posedge clock) begin
      n_ff     <= n_in;
      x_ff     <= x_in;
      steps_ff <= steps_in;
      inv_ff   <= inv_in;
   end

   // response register
   always_comb begin
      out_in       = out_ff;
      rsp_valid_in = rsp_valid_ff;
      if (out_load) begin
         out_in.root_estimate = x_ff[nsf_pkg::ROOT_W-1:0];
         out_in.invalid       = inv_ff;
         rsp_valid_in         = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_ff <= out_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = out_ff;

   a_one_request: assert property (@(posedge clock) disable iff (reset)
      accept |=> !cw.accept)
      else $error("second request taken while one is in work");

   a_invalid_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && out_ff.invalid) |-> out_ff.root_estimate == '0)
      else $error("invalid response with nonzero estimate");

   a_rsp_from_load: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(cw.out_load))
      else $error("response raised without a result step");

endmodule

@@ verif/newton_sqrt_fixed_test.sv @@
// newton_sqrt_fixed_test: self-checking testbench for the newton square root block
// drives directed and random requests, checks every response against a table value or its own predictor
// depends on nsf_pkg and newton_sqrt_fixed

module newton_sqrt_fixed_test;

   localparam int FRAC            = nsf_pkg::FRAC_BITS_DEF;
   localparam int STEP_LIMIT      = nsf_pkg::MAX_STEPS_DEF;
   localparam int RANDOM_REQUESTS = 750;
   localparam int DIRECTED_ROWS   = 17;
   localparam int DRAIN_CYCLES    = 100;

   typedef struct packed {
      logic             known;
      nsf_pkg::req_type req;
      nsf_pkg::rsp_type rsp;
   } stim_row_type;

   typedef enum logic [1:0] {
      STALL_NONE,
      STALL_LIGHT,
      STALL_HEAVY
   } stall_mode_type;

   logic             clock     = 1'b0;
   logic             reset     = 1'b1;
   logic             req_valid = 1'b0;
   logic             req_stall;
   nsf_pkg::req_type req_data  = '0;
   logic             rsp_valid;
   logic             rsp_stall = 1'b0;
   nsf_pkg::rsp_type rsp_data;

   nsf_pkg::rsp_type root_q[$];
   int               mismatches = 0;
   int               burst_left = 0;
   stall_mode_type   stall_mode = STALL_NONE;
   int               stall_left = 0;

   newton_sqrt_fixed i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   // one row of the directed table; root and invalid only count when known is set
   function automatic stim_row_type stim_row(logic known,
                                             logic [nsf_pkg::RADICAND_W-1:0] radicand,
                                             logic [nsf_pkg::STEP_W-1:0] steps,
                                             logic [nsf_pkg::ROOT_W-1:0] root,
                                             logic invalid);
      stim_row_type row;
      row.known              = known;
      row.req.radicand       = radicand;
      row.req.step_count     = steps;
      row.rsp.root_estimate  = root;
      row.rsp.invalid        = invalid;
      return row;
   endfunction

   // newton iteration in unsigned fixed point, truncating quotient and halving
   function automatic nsf_pkg::rsp_type newton_root(nsf_pkg::req_type r);
      nsf_pkg::rsp_type res;
      int               steps;
      int               k;
      logic [63:0]      num;
      logic [63:0]      est;
      logic [63:0]      quot;
      logic [127:0]     scaled;
      logic [127:0]     wide_quot;
      logic [64:0]      sum;
      res   = '0;
      steps = r.step_count;
      if (steps > STEP_LIMIT) begin
         steps = STEP_LIMIT;
      end
      if (r.radicand == '0) begin
         // nothing to divide by: flag it when any step is asked for
         res.invalid = (steps != 0);
         return res;
      end
      num    = 64'(r.radicand);
      est    = num << (FRAC - 1);
      scaled = {64'b0, num} << (2 * FRAC);
      for (k = 0; k < steps; k++) begin
         if (est == '0) begin
            quot = '1;
         end else begin
            wide_quot = scaled / {64'b0, est};
            quot      = (wide_quot[127:64] != '0) ? '1 : wide_quot[63:0];
         end
         sum = {1'b0, est} + {1'b0, quot};
         est = sum[64:1];
      end
      res.root_estimate = est[nsf_pkg::ROOT_W-1:0];
      return res;
   endfunction

   task automatic report_mismatch(string what);
      $display("%0t mismatch: %s", $realtime, what);
      mismatches++;
   endtask

   // offer one request, in bursts with random gaps, and hold it until accepted
   task automatic send_request(nsf_pkg::req_type r, nsf_pkg::rsp_type want);
      int gap;
      gap = 0;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 10);
         gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      end
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= r;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      root_q.push_back(want);
      burst_left--;
   endtask

   // directed requests: extremes, zero radicand with and without steps, long runs
   stim_row_type directed [DIRECTED_ROWS] = '{
      stim_row(1'b1, 31'd0,           6'd0,  48'h0,              1'b0),
      stim_row(1'b1, 31'd0,           6'd1,  48'h0,              1'b1),
      stim_row(1'b1, 31'd0,           6'd63, 48'h0,              1'b1),
      stim_row(1'b1, 31'd1,           6'd0,  48'h0000_0000_8000, 1'b0),
      stim_row(1'b1, 31'h7FFF_FFFF,   6'd0,  48'h3FFF_FFFF_8000, 1'b0),
      stim_row(1'b1, 31'h4000_0000,   6'd0,  48'h2000_0000_0000, 1'b0),
      stim_row(1'b0, 31'd1,           6'd1,  48'h0,              1'b0),
      stim_row(1'b0, 31'd1,           6'd63, 48'h0,              1'b0),
      stim_row(1'b0, 31'd4,           6'd8,  48'h0,              1'b0),
      stim_row(1'b0, 31'd2,           6'd40, 48'h0,              1'b0),
      stim_row(1'b0, 31'd3,           6'd2,  48'h0,              1'b0),
      stim_row(1'b0, 31'h7FFF_FFFF,   6'd1,  48'h0,              1'b0),
      stim_row(1'b0, 31'h7FFF_FFFF,   6'd25, 48'h0,              1'b0),
      stim_row(1'b0, 31'h7FFF_FFFF,   6'd63, 48'h0,              1'b0),
      stim_row(1'b0, 31'h5555_5555,   6'h2A, 48'h0,              1'b0),
      stim_row(1'b0, 31'h2AAA_AAAA,   6'h15, 48'h0,              1'b0),
      stim_row(1'b0, 31'd4100625,     6'd30, 48'h0,              1'b0)
   };

   // clock
   initial begin
      forever #5 clock = ~clock;
   end

   // run limit, well above the slowest correct run
   initial begin
      #150_000_000;
      $display("newton_sqrt_fixed_test failed");
      $finish;
   end

   // response stall: modes of no, light and heavy stalling, each held for a while
   always @(posedge clock) begin
      if (stall_left == 0) begin
         stall_mode <= stall_mode_type'($urandom_range(0, 2));
         stall_left <= $urandom_range(100, 3000);
      end else begin
         stall_left <= stall_left - 1;
      end
      case (stall_mode)
         STALL_NONE:  rsp_stall <= 1'b0;
         STALL_LIGHT: rsp_stall <= ($urandom_range(0, 3) == 0);
         default:     rsp_stall <= ($urandom_range(0, 3) != 0);
      endcase
   end

   // compare each accepted response with the oldest outstanding prediction
   always @(posedge clock) begin : check_responses
      nsf_pkg::rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (root_q.size() == 0) begin
            report_mismatch($sformatf("unexpected response root %h invalid %b",
                                      rsp_data.root_estimate, rsp_data.invalid));
         end else begin
            want = root_q.pop_front();
            if (rsp_data.root_estimate !== want.root_estimate) begin
               report_mismatch($sformatf("root_estimate %h, predicted %h",
                                         rsp_data.root_estimate, want.root_estimate));
            end
            if (rsp_data.invalid !== want.invalid) begin
               report_mismatch($sformatf("invalid %b, predicted %b",
                                         rsp_data.invalid, want.invalid));
            end
         end
      end
   end

   // reset, directed table, random requests, drain
   initial begin
      stim_row_type     row;
      nsf_pkg::req_type r;
      int               i;
      int               k;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      for (i = 0; i < DIRECTED_ROWS; i++) begin
         row = directed[i];
         send_request(row.req, row.known ? row.rsp : newton_root(row.req));
      end

      for (i = 0; i < RANDOM_REQUESTS; i++) begin
         // radicand: half full range, with zero, small values, squares, powers of two, near maximum
         case ($urandom_range(0, 9))
            0: r.radicand = '0;
            1: r.radicand = nsf_pkg::RADICAND_W'($urandom_range(1, 255));
            2: begin
               k          = $urandom_range(1, 46340);
               r.radicand = nsf_pkg::RADICAND_W'(k * k);
            end
            3: r.radicand = nsf_pkg::RADICAND_W'(1)
                            << $urandom_range(0, nsf_pkg::RADICAND_W - 1);
            4: r.radicand = 31'h7FFF_FFFF - nsf_pkg::RADICAND_W'($urandom_range(0, 255));
            default: r.radicand = nsf_pkg::RADICAND_W'($urandom);
         endcase
         // step count: mostly short runs, a few up to the full range
         case ($urandom_range(0, 9)) inside
            [7:8]:   r.step_count = nsf_pkg::STEP_W'($urandom_range(8, 24));
            9:       r.step_count = nsf_pkg::STEP_W'($urandom_range(25, 63));
            default: r.step_count = nsf_pkg::STEP_W'($urandom_range(0, 7));
         endcase
         send_request(r, newton_root(r));
      end
      req_valid <= 1'b0;

      while (root_q.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatches == 0) begin
         $display("newton_sqrt_fixed_test passed");
      end else begin
         $display("newton_sqrt_fixed_test failed");
      end
      $finish;
   end

endmodule
